// ----- rtl/core/bfdos_pkg.sv -----
package bfdos_pkg;

  localparam int DepthDefault = 8;
  localparam logic [3:0] CapReset = 4'd5;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;
  localparam logic [1:0] OP_DISPLAY = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               found;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_DROP,
    S_DEL,
    S_SCAN,
    S_DISP,
    S_RESP
  } state_t;

endpackage

// ----- rtl/core/bfdos_mem.sv -----
module bfdos_mem #(
  parameter int DEPTH = bfdos_pkg::DepthDefault,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued, so a stalled display keeps its word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bfdos_ctrl.sv -----
module bfdos_ctrl #(
  parameter int DEPTH = bfdos_pkg::DepthDefault,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  bfdos_pkg::in_t   in_data,
  output logic             res_valid,
  input  logic             res_ready,
  output bfdos_pkg::out_t  res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [31:0]      mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [31:0]      mem_rdata
);

  localparam int SW = CW + 1;
  localparam int EW = (CW > 4) ? CW + 1 : 5;

  bfdos_pkg::state_t state, state_next;
  bfdos_pkg::in_t    item;
  bfdos_pkg::out_t   res_q, res_q_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic              hit, hit_next;
  logic [3:0]        cap;
  logic [EW-1:0]     eff_cap;
  logic              full;
  logic              idx_last;
  logic              match;

  // Ring slot of the entry that lies off places after the head.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    if (cap == 4'd0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap) > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = EW'(cap);
    end
  end

  assign full     = (EW'(count) >= eff_cap) && (count != '0);
  assign idx_last = (CW'(idx + CW'(1)) == count);
  assign match    = (mem_rdata == item.value);
  assign in_stall = (state != bfdos_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfdos_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      cap   <= bfdos_pkg::CapReset;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
    res_q <= res_q_next;
    idx   <= idx_next;
    hit   <= hit_next;
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    hit_next   = hit;
    res_q_next = res_q;
    mem_we     = 1'b0;
    mem_waddr  = slot(head, count);
    mem_wdata  = item.value;
    mem_re     = 1'b0;
    mem_raddr  = head;
    res_valid  = 1'b0;
    res        = res_q;

    unique case (state)
      bfdos_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bfdos_pkg::S_OP;
        end
      end

      bfdos_pkg::S_OP: begin
        res_q_next = '{status: bfdos_pkg::ST_DONE, data: '0, found: 1'b0, last: 1'b1};
        idx_next   = '0;
        hit_next   = 1'b0;
        unique case (item.op)
          bfdos_pkg::OP_INSERT: begin
            if (full) begin
              mem_re     = 1'b1;
              state_next = bfdos_pkg::S_DROP;
            end else begin
              mem_we     = 1'b1;
              count_next = CW'(count + CW'(1));
              state_next = bfdos_pkg::S_RESP;
            end
          end
          bfdos_pkg::OP_DELETE: begin
            if (count == '0) begin
              res_q_next.status = bfdos_pkg::ST_EMPTY;
              state_next        = bfdos_pkg::S_RESP;
            end else begin
              mem_re     = 1'b1;
              state_next = bfdos_pkg::S_DEL;
            end
          end
          bfdos_pkg::OP_SEARCH: begin
            if (count == '0) begin
              state_next = bfdos_pkg::S_RESP;
            end else begin
              mem_re     = 1'b1;
              state_next = bfdos_pkg::S_SCAN;
            end
          end
          bfdos_pkg::OP_DISPLAY: begin
            if (count == '0) begin
              res_q_next.status = bfdos_pkg::ST_EMPTY;
              state_next        = bfdos_pkg::S_RESP;
            end else begin
              mem_re     = 1'b1;
              state_next = bfdos_pkg::S_DISP;
            end
          end
          default: begin
            state_next = bfdos_pkg::S_IDLE;
          end
        endcase
      end

      bfdos_pkg::S_DROP: begin
        // The oldest word is out of the RAM; the new value goes in after the newest entry.
        mem_we     = 1'b1;
        head_next  = slot(head, CW'(1));
        res_q_next = '{status: bfdos_pkg::ST_DROPPED, data: mem_rdata,
                       found: 1'b0, last: 1'b1};
        state_next = bfdos_pkg::S_RESP;
      end

      bfdos_pkg::S_DEL: begin
        head_next  = slot(head, CW'(1));
        count_next = CW'(count - CW'(1));
        res_q_next = '{status: bfdos_pkg::ST_DONE, data: mem_rdata,
                       found: 1'b0, last: 1'b1};
        state_next = bfdos_pkg::S_RESP;
      end

      bfdos_pkg::S_SCAN: begin
        if (idx_last) begin
          res_q_next = '{status: bfdos_pkg::ST_DONE, data: '0,
                         found: hit | match, last: 1'b1};
          state_next = bfdos_pkg::S_RESP;
        end else begin
          hit_next  = hit | match;
          idx_next  = CW'(idx + CW'(1));
          mem_re    = 1'b1;
          mem_raddr = slot(head, CW'(idx + CW'(1)));
        end
      end

      bfdos_pkg::S_DISP: begin
        res_valid = 1'b1;
        res = '{status: bfdos_pkg::ST_DONE, data: mem_rdata, found: 1'b0, last: idx_last};
        if (res_ready) begin
          if (idx_last) begin
            state_next = bfdos_pkg::S_IDLE;
          end else begin
            idx_next  = CW'(idx + CW'(1));
            mem_re    = 1'b1;
            mem_raddr = slot(head, CW'(idx + CW'(1)));
          end
        end
      end

      bfdos_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bfdos_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bfdos_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bfdos_pkg::S_SCAN || state == bfdos_pkg::S_DISP) |-> (idx < count))
    else $error("scan index beyond stored entries");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (state == bfdos_pkg::S_DEL) |=> (count == CW'($past(count) - CW'(1))))
    else $error("delete did not shrink the queue by one");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (state == bfdos_pkg::S_DROP) |=> (count == $past(count) && head != $past(head)
                                      || DEPTH == 1))
    else $error("overwrite insert changed the count or kept the head");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> (state == bfdos_pkg::S_IDLE))
    else $error("sequencer busy after the final word of an item");

endmodule

// ----- rtl/core/bounded_fifo_drop_oldest_search_core.sv -----
// Channel   Direction  Handshake          Word
// input     in         in_valid/in_stall  in_data  (op, value)
// output    out        out_valid/out_stall out_data (status, data, found, last)
// config    in         cfg_we             cfg_wdata (capacity_limit)
//
// Entries live in one RAM with a single read port and a registered read. An insert
// that overwrites the oldest word passes a drop state; delete reads the head unless
// the queue is empty. Search reads one entry per cycle; an empty queue answers at
// once. Display sends one word per cycle after its first read while not stalled.
// Reset clears head and count and sets the capacity to 5; RAM contents are not cleared.
// A registered output word parts the sides; items are taken only while the sequencer idles.
module bounded_fifo_drop_oldest_search_core #(
  parameter int DEPTH = bfdos_pkg::DepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  bfdos_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output bfdos_pkg::out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic            res_valid;
  logic            res_ready;
  bfdos_pkg::out_t res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [31:0]     mem_rdata;

  bfdos_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bfdos_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new word once the held one is gone or leaving.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

endmodule
